@@ hw/rtl/fvn_pkg.sv @@
// Shared constants, the point word type and the arithmetic helpers of the
// fractal value noise block. No dependencies.
package fvn_pkg;

   // Default sizes of the block.
   localparam int MAX_OCTAVES_DEF = 8;
   localparam int FRAC_BITS_DEF   = 16;

   // Fixed field widths.
   localparam int COORD_W  = 28;
   localparam int VALUE_W  = 16;
   localparam int RECIP_W  = 18;
   localparam int QUOT_W   = 17;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int COUNT_W  = 4;

   // Register indexes, decoded from the word address bit.
   localparam logic REG_OCTAVE_COUNT = 1'b0;
   localparam logic REG_NORMALIZE    = 1'b1;

   // Register reset values.
   localparam logic [COUNT_W-1:0] OCTAVE_COUNT_RST = 4'd4;
   localparam logic               NORMALIZE_RST    = 1'b1;

   // Lattice hash multipliers.
   localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
   localparam logic [31:0] HASH_MUL_Y   = 32'd668265263;
   localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;
   localparam logic [31:0] HASH_MASK    = 32'h7FFF_FFFF;

   // Three in Q2.16, the smoothstep offset.
   localparam logic [17:0] SMOOTH_THREE = 18'd196608;

   // Point word handed from one octave cell to the next.
   typedef struct packed {
      logic                      valid;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } point_type;

   // Finish the corner hash: mix, multiply, mix again, keep the top 16 of 31 bits.
   function automatic logic [VALUE_W-1:0] corner_value(input logic [31:0] n);
      logic [31:0] t;
      logic [31:0] m;
      logic [31:0] h;
      t = n ^ 32'($signed(n) >>> 13);
      m = t * HASH_MUL_MIX;
      h = (m ^ 32'($signed(m) >>> 16)) & HASH_MASK;
      return h[30:15];
   endfunction

   // Second half of smoothstep: (f*f >> 16) * (3 - 2f) >> 16.
   function automatic logic [VALUE_W-1:0] smooth_step(input logic [VALUE_W-1:0] sq,
                                                      input logic [VALUE_W-1:0] f);
      logic [17:0] t;
      logic [33:0] p;
      t = SMOOTH_THREE - {1'b0, f, 1'b0};
      p = 34'(sq) * 34'(t);
      return p[31:16];
   endfunction

   // Blend p toward q by s, written as p + (q - p) * s >> 16 with a floor shift.
   function automatic logic [VALUE_W-1:0] lerp16(input logic [VALUE_W-1:0] p,
                                                 input logic [VALUE_W-1:0] q,
                                                 input logic [VALUE_W-1:0] s);
      logic signed [16:0] d;
      logic signed [33:0] m;
      d = $signed({1'b0, q}) - $signed({1'b0, p});
      m = 34'(d) * 34'($signed({1'b0, s}));
      return p + VALUE_W'(m >>> 16);
   endfunction

endpackage

@@ hw/rtl/fvn_cell.sv @@
// One octave cell: splits the scaled point, hashes the eight lattice corners,
// blends them and adds the weighted octave value to the running sum.
// Depends on fvn_pkg.
module fvn_cell #(
   parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF,
   parameter int FRAC_BITS   = fvn_pkg::FRAC_BITS_DEF,
   parameter int OCT_IDX     = 0,
   parameter int ACC_W       = 16 + MAX_OCTAVES,
   parameter int CNT_W       = $clog2(MAX_OCTAVES + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic [CNT_W-1:0]       count_eff,
   input  fvn_pkg::point_type     pt_in,
   output fvn_pkg::point_type     pt_out,
   input  logic [ACC_W-1:0]       acc_in,
   output logic                   acc_valid_out,
   output logic [ACC_W-1:0]       acc_out
);

   localparam int SHIFT   = MAX_OCTAVES - 1 - OCT_IDX;
   localparam int SCALE_W = 64;
   localparam int CW      = fvn_pkg::COORD_W;
   localparam int VW      = fvn_pkg::VALUE_W;

   // Split each coordinate, scaled by two to the octave index.
   logic signed [CW-1:0] crd [3];
   logic [31:0]          a_cell_in [3];
   logic [VW-1:0]        a_frac_in [3];

   assign crd[0] = pt_in.x;
   assign crd[1] = pt_in.y;
   assign crd[2] = pt_in.z;

   for (genvar d = 0; d < 3; d++) begin : g_split
      logic [SCALE_W-1:0]   scaled;
      logic [FRAC_BITS-1:0] frac_raw;
      assign scaled       = {{(SCALE_W - CW){crd[d][CW-1]}}, crd[d]} << OCT_IDX;
      assign a_cell_in[d] = scaled[FRAC_BITS+31:FRAC_BITS];
      assign frac_raw     = scaled[FRAC_BITS-1:0];
      assign a_frac_in[d] = VW'((48'(frac_raw) << 16) >> FRAC_BITS);
   end

   fvn_pkg::point_type a_pt_ff;
   logic [31:0]        a_cell_ff [3];
   logic [VW-1:0]      a_frac_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_pt_ff <= '0;
      end else if (en) begin
         a_pt_ff <= pt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_cell_ff <= a_cell_in;
         a_frac_ff <= a_frac_in;
      end
   end

   assign pt_out = a_pt_ff;

   // Valid bits of stages B through H.
   logic [6:0] vld_ff;
   logic [6:0] vld_in;

   assign vld_in = {vld_ff[5:0], a_pt_ff.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // Stage B: hash products of the x and y indexes, squares of the fractions.
   logic [31:0]   b_px_in, b_py_in;
   logic [VW-1:0] b_sq_in [3];
   logic [31:0]   b_px_ff, b_py_ff, b_z_ff;
   logic [VW-1:0] b_sq_ff [3];
   logic [VW-1:0] b_frac_ff [3];

   assign b_px_in = a_cell_ff[0] * fvn_pkg::HASH_MUL_X;
   assign b_py_in = a_cell_ff[1] * fvn_pkg::HASH_MUL_Y;

   for (genvar d = 0; d < 3; d++) begin : g_square
      logic [31:0] sq_full;
      assign sq_full    = 32'(a_frac_ff[d]) * 32'(a_frac_ff[d]);
      assign b_sq_in[d] = sq_full[31:16];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_px_ff   <= b_px_in;
         b_py_ff   <= b_py_in;
         b_z_ff    <= a_cell_ff[2];
         b_sq_ff   <= b_sq_in;
         b_frac_ff <= a_frac_ff;
      end
   end

   // Stage C: raw hash sums of the eight corners, smoothstep weights.
   logic [31:0]   c_n_in [8];
   logic [VW-1:0] c_s_in [3];
   logic [31:0]   c_n_ff [8];
   logic [VW-1:0] c_s_ff [3];

   for (genvar k = 0; k < 8; k++) begin : g_corner_sum
      localparam logic [31:0] OFS_X = ((k & 1) != 0) ? fvn_pkg::HASH_MUL_X : 32'd0;
      localparam logic [31:0] OFS_Y = ((k & 2) != 0) ? fvn_pkg::HASH_MUL_Y : 32'd0;
      localparam logic [31:0] OFS_Z = ((k & 4) != 0) ? 32'd1 : 32'd0;
      assign c_n_in[k] = b_px_ff + b_py_ff + b_z_ff + (OFS_X + OFS_Y + OFS_Z);
   end

   for (genvar d = 0; d < 3; d++) begin : g_smooth
      assign c_s_in[d] = fvn_pkg::smooth_step(b_sq_ff[d], b_frac_ff[d]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_n_ff <= c_n_in;
         c_s_ff <= c_s_in;
      end
   end

   // Stage D: finish the corner hashes.
   logic [VW-1:0] d_v_in [8];
   logic [VW-1:0] d_v_ff [8];
   logic [VW-1:0] d_s_ff [3];

   for (genvar k = 0; k < 8; k++) begin : g_hash
      assign d_v_in[k] = fvn_pkg::corner_value(c_n_ff[k]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_v_ff <= d_v_in;
         d_s_ff <= c_s_ff;
      end
   end

   // Stage E: blend along x.
   logic [VW-1:0] e_in [4];
   logic [VW-1:0] e_ff [4];
   logic [VW-1:0] e_sy_ff, e_sz_ff;

   for (genvar j = 0; j < 4; j++) begin : g_blend_x
      assign e_in[j] = fvn_pkg::lerp16(d_v_ff[2*j], d_v_ff[2*j+1], d_s_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_ff    <= e_in;
         e_sy_ff <= d_s_ff[1];
         e_sz_ff <= d_s_ff[2];
      end
   end

   // Stage F: blend along y.
   logic [VW-1:0] f_in [2];
   logic [VW-1:0] f_ff [2];
   logic [VW-1:0] f_sz_ff;

   assign f_in[0] = fvn_pkg::lerp16(e_ff[0], e_ff[1], e_sy_ff);
   assign f_in[1] = fvn_pkg::lerp16(e_ff[2], e_ff[3], e_sy_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         f_ff    <= f_in;
         f_sz_ff <= e_sz_ff;
      end
   end

   // Stage G: blend along z, giving the octave value.
   logic [VW-1:0] g_n_in, g_n_ff;

   assign g_n_in = fvn_pkg::lerp16(f_ff[0], f_ff[1], f_sz_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         g_n_ff <= g_n_in;
      end
   end

   // Stage H: add the weighted octave value when this octave is enabled.
   logic             oct_active;
   logic [ACC_W-1:0] acc_term;
   logic [ACC_W-1:0] acc_in_sum;
   logic [ACC_W-1:0] acc_ff;

   assign oct_active = 32'(count_eff) > 32'(OCT_IDX);
   assign acc_term   = oct_active ? (ACC_W'(g_n_ff) << SHIFT) : '0;
   assign acc_in_sum = acc_in + acc_term;

   always_ff @(posedge clock) begin
      if (en) begin
         acc_ff <= acc_in_sum;
      end
   end

   assign acc_valid_out = vld_ff[6];
   assign acc_out       = acc_ff;

endmodule

@@ hw/rtl/fvn_norm.sv @@
// Final scaling of the octave sum: division by the total amplitude through a
// reciprocal multiply with one correction step, or clamping. Depends on fvn_pkg.
module fvn_norm #(
   parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF,
   parameter int ACC_W       = 16 + MAX_OCTAVES,
   parameter int CNT_W       = $clog2(MAX_OCTAVES + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        valid_in,
   input  logic [ACC_W-1:0]            acc_in,
   input  logic [CNT_W-1:0]            count_eff,
   input  logic                        normalize,
   output logic                        valid_out,
   output logic [fvn_pkg::VALUE_W-1:0] value_out
);

   localparam int RW     = fvn_pkg::RECIP_W;
   localparam int QW     = fvn_pkg::QUOT_W;
   localparam int VW     = fvn_pkg::VALUE_W;
   localparam int TOT_W  = MAX_OCTAVES;
   localparam int TBL_N  = 2 ** CNT_W;
   localparam int PROD_W = ACC_W + RW;

   // Total amplitude and its reciprocal for every octave count.
   logic [TOT_W-1:0] total_tbl [TBL_N];
   logic [RW-1:0]    recip_tbl [TBL_N];

   for (genvar k = 0; k < TBL_N; k++) begin : g_tbl
      localparam int KK = (k < 1) ? 1 : ((k > MAX_OCTAVES) ? MAX_OCTAVES : k);
      localparam logic [63:0] TOTAL =
         (64'd1 << MAX_OCTAVES) - (64'd1 << (MAX_OCTAVES - KK));
      localparam logic [63:0] RECIP = (64'd1 << ACC_W) / TOTAL;
      assign total_tbl[k] = TOT_W'(TOTAL);
      assign recip_tbl[k] = RW'(RECIP);
   end

   logic [2:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], valid_in};
      end
   end

   // Stage P: sum times reciprocal.
   logic [PROD_W-1:0] p_prod_in, p_prod_ff;
   logic [ACC_W-1:0]  p_acc_ff;
   logic [TOT_W-1:0]  p_total_ff;

   assign p_prod_in = PROD_W'(acc_in) * PROD_W'(recip_tbl[count_eff]);

   always_ff @(posedge clock) begin
      if (en) begin
         p_prod_ff  <= p_prod_in;
         p_acc_ff   <= acc_in;
         p_total_ff <= total_tbl[count_eff];
      end
   end

   // Stage Q: quotient estimate, one low at most, and its back product.
   logic [QW-1:0]       q_est;
   logic [ACC_W+QW-1:0] q_back;
   logic [QW-1:0]       q_q_ff;
   logic [ACC_W-1:0]    q_back_ff, q_acc_ff;
   logic [TOT_W-1:0]    q_total_ff;

   assign q_est  = p_prod_ff[ACC_W+QW-1:ACC_W];
   assign q_back = (ACC_W + QW)'(q_est) * (ACC_W + QW)'(p_total_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         q_q_ff     <= q_est;
         q_back_ff  <= q_back[ACC_W-1:0];
         q_acc_ff   <= p_acc_ff;
         q_total_ff <= p_total_ff;
      end
   end

   // Stage R: correct the quotient, saturate, pick the mode.
   logic [ACC_W-1:0] rem;
   logic [QW:0]      quot;
   logic [ACC_W-1:0] clamp_full;
   logic [VW-1:0]    norm_sat, clamp_sat, r_value_in, r_value_ff;

   assign rem        = q_acc_ff - q_back_ff;
   assign quot       = {1'b0, q_q_ff} + (QW + 1)'(rem >= ACC_W'(q_total_ff));
   assign norm_sat   = (quot > (QW + 1)'({VW{1'b1}})) ? {VW{1'b1}} : quot[VW-1:0];
   assign clamp_full = q_acc_ff >> (MAX_OCTAVES - 1);
   assign clamp_sat  = (clamp_full > ACC_W'({VW{1'b1}})) ? {VW{1'b1}} : clamp_full[VW-1:0];
   assign r_value_in = normalize ? norm_sat : clamp_sat;

   always_ff @(posedge clock) begin
      if (en) begin
         r_value_ff <= r_value_in;
      end
   end

   assign valid_out = vld_ff[2];
   assign value_out = r_value_ff;

endmodule

@@ hw/rtl/fractal_value_noise_3d.sv @@
// Fractal value noise of a 3D point: a row of octave cells, the final scaling
// and an output stage with a skid word. Depends on fvn_pkg, fvn_cell, fvn_norm.
// Throughput: one point per cycle while the skid word is empty; each octave cell is
// an eight-stage pipeline fed from its neighbor's first register, so every cell
// takes a new point each cycle unless the pipeline is stalled.
// Reset: synchronous; clears all valid bits, octave_count to 4, normalize_mode to 1.
module fractal_value_noise_3d #(
   parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF,
   parameter int FRAC_BITS   = fvn_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [fvn_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [fvn_pkg::COORD_W-1:0] req_coord_y,
   input  logic signed [fvn_pkg::COORD_W-1:0] req_coord_z,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [fvn_pkg::VALUE_W-1:0]        rsp_noise_value,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fvn_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [fvn_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [fvn_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                              pready
);

   localparam int ACC_W = 16 + MAX_OCTAVES;
   localparam int CNT_W = $clog2(MAX_OCTAVES + 1);
   localparam int VW    = fvn_pkg::VALUE_W;
   localparam int DW    = fvn_pkg::CSR_DATA_W;
   localparam int NW    = fvn_pkg::COUNT_W;

   // Configuration registers.
   logic [NW-1:0] octave_count_ff;
   logic          normalize_ff;
   logic          csr_wr;

   assign csr_wr = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         octave_count_ff <= fvn_pkg::OCTAVE_COUNT_RST;
         normalize_ff    <= fvn_pkg::NORMALIZE_RST;
      end else if (csr_wr) begin
         case (paddr[2])
            fvn_pkg::REG_OCTAVE_COUNT: octave_count_ff <= pwdata[NW-1:0];
            fvn_pkg::REG_NORMALIZE:    normalize_ff    <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         fvn_pkg::REG_OCTAVE_COUNT: prdata = DW'(octave_count_ff);
         fvn_pkg::REG_NORMALIZE:    prdata = DW'(normalize_ff);
         default:                   prdata = '0;
      endcase
   end

   // Octave count held to one through MAX_OCTAVES.
   logic [CNT_W-1:0] count_eff;

   always_comb begin
      if (octave_count_ff == '0) begin
         count_eff = CNT_W'(1);
      end else if (32'(octave_count_ff) > 32'(MAX_OCTAVES)) begin
         count_eff = CNT_W'(MAX_OCTAVES);
      end else begin
         count_eff = CNT_W'(octave_count_ff);
      end
   end

   // The whole pipeline advances unless the skid word is occupied.
   logic skid_valid_ff;
   logic en;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // Chain of octave cells: points move one cell per cycle while not stalled, sums follow behind.
   fvn_pkg::point_type pts  [MAX_OCTAVES+1];
   logic [ACC_W-1:0]   accs [MAX_OCTAVES+1];
   logic               acc_vld [MAX_OCTAVES+1];

   assign pts[0]     = '{valid: req_valid, x: req_coord_x, y: req_coord_y, z: req_coord_z};
   assign accs[0]    = '0;
   assign acc_vld[0] = 1'b0;

   for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_cell
      fvn_cell #(
         .MAX_OCTAVES(MAX_OCTAVES),
         .FRAC_BITS  (FRAC_BITS),
         .OCT_IDX    (i),
         .ACC_W      (ACC_W),
         .CNT_W      (CNT_W)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .en           (en),
         .count_eff    (count_eff),
         .pt_in        (pts[i]),
         .pt_out       (pts[i+1]),
         .acc_in       (accs[i]),
         .acc_valid_out(acc_vld[i+1]),
         .acc_out      (accs[i+1])
      );
   end

   // Division by total amplitude or clamping.
   logic          last_valid;
   logic [VW-1:0] last_value;

   fvn_norm #(
      .MAX_OCTAVES(MAX_OCTAVES),
      .ACC_W      (ACC_W),
      .CNT_W      (CNT_W)
   ) u_norm (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .valid_in (acc_vld[MAX_OCTAVES]),
      .acc_in   (accs[MAX_OCTAVES]),
      .count_eff(count_eff),
      .normalize(normalize_ff),
      .valid_out(last_valid),
      .value_out(last_value)
   );

   // Output register with one skid word behind it.
   logic          out_valid_ff, out_valid_in;
   logic [VW-1:0] out_value_ff, out_value_in;
   logic          skid_valid_in;
   logic [VW-1:0] skid_value_ff, skid_value_in;
   logic          push, pop;

   assign push = en && last_valid;
   assign pop  = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_value_in  = out_value_ff;
      skid_valid_in = skid_valid_ff;
      skid_value_in = skid_value_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_value_in  = skid_value_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_value_in = last_value;
         end else begin
            skid_valid_in = 1'b1;
            skid_value_in = last_value;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff  <= out_value_in;
      skid_value_ff <= skid_value_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_noise_value = out_value_ff;

   // The skid word is only ever filled behind a waiting output word.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held without an output word");

   // The skid word fills only when the output side stalled.
   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_stall))
      else $error("skid word filled without a stall");

   // A taken output drains the skid word in the next cycle.
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_stall) |=> !skid_valid_ff)
      else $error("skid word not drained");

   // The effective octave count stays within one through MAX_OCTAVES.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_eff != '0) && (32'(count_eff) <= 32'(MAX_OCTAVES)))
      else $error("effective octave count out of range");

endmodule

@@ verif/noise_checker.sv @@
// Checker for the fractal value noise block: watches the point, result and
// register ports, predicts each noise word and compares it. Depends on fvn_pkg.
module noise_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic signed [fvn_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [fvn_pkg::COORD_W-1:0] req_coord_y,
   input  logic signed [fvn_pkg::COORD_W-1:0] req_coord_z,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [fvn_pkg::VALUE_W-1:0]        rsp_noise_value,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [fvn_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [fvn_pkg::CSR_DATA_W-1:0]     pwdata,
   input  logic                               pready,
   output int                                 fail_count,
   output int                                 pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import fvn_pkg::*;

   localparam int OCTAVES = MAX_OCTAVES_DEF;

   // Our own copy of the two registers.
   logic [COUNT_W-1:0] octave_count;
   logic               normalize_mode;

   // Noise words predicted for accepted points, oldest first.
   logic [VALUE_W-1:0] expected_noise [$];

   initial begin
      fail_count = 0;
      pending = 0;
   end

   // Hash of one lattice corner, top 16 of the 31 kept bits.
   function automatic logic [15:0] lattice_value(input logic [31:0] a, input logic [31:0] b,
                                                 input logic [31:0] c);
      logic [31:0] n;
      n = a * HASH_MUL_X + b * HASH_MUL_Y + c;
      n = (n ^ 32'($signed(n) >>> 13)) * HASH_MUL_MIX;
      n = (n ^ 32'($signed(n) >>> 16)) & HASH_MASK;
      return n[30:15];
   endfunction

   // Smoothstep of a Q0.16 fraction, truncated at each step.
   function automatic logic [15:0] fade(input logic [15:0] f);
      logic [63:0] sq;
      logic [63:0] t;
      sq = (64'(f) * 64'(f)) >> 16;
      t = 64'd196608 - 2 * 64'(f);
      return 16'((sq * t) >> 16);
   endfunction

   function automatic logic [15:0] blend(input logic [15:0] p, input logic [15:0] q,
                                         input logic [15:0] s);
      logic [63:0] r;
      r = 64'(p) * (64'd65536 - 64'(s)) + 64'(q) * 64'(s);
      return 16'(r >> 16);
   endfunction

   // One octave: lattice cell and fraction per axis, then a trilinear blend.
   function automatic logic [15:0] octave_value(input logic signed [63:0] x,
                                                input logic signed [63:0] y,
                                                input logic signed [63:0] z);
      logic [31:0] xi, yi, zi;
      logic [15:0] u, v, w, c00, c10, c01, c11;
      xi = 32'(x >>> 16);
      yi = 32'(y >>> 16);
      zi = 32'(z >>> 16);
      u = fade(x[15:0]);
      v = fade(y[15:0]);
      w = fade(z[15:0]);
      c00 = blend(lattice_value(xi, yi, zi), lattice_value(xi + 1, yi, zi), u);
      c10 = blend(lattice_value(xi, yi + 1, zi), lattice_value(xi + 1, yi + 1, zi), u);
      c01 = blend(lattice_value(xi, yi, zi + 1), lattice_value(xi + 1, yi, zi + 1), u);
      c11 = blend(lattice_value(xi, yi + 1, zi + 1),
                  lattice_value(xi + 1, yi + 1, zi + 1), u);
      return blend(blend(c00, c10, v), blend(c01, c11, v), w);
   endfunction

   // Octave sum, then normalized or clamped, saturated to 16 bits.
   function automatic logic [15:0] predict_noise(input logic signed [COORD_W-1:0] x,
                                                 input logic signed [COORD_W-1:0] y,
                                                 input logic signed [COORD_W-1:0] z);
      logic signed [63:0] sx, sy, sz;
      logic [63:0] acc, total, res;
      int count;
      sx = x;
      sy = y;
      sz = z;
      acc = 0;
      total = 0;
      count = octave_count;
      // A count of zero means one octave; too many saturates.
      if (count == 0) begin
         count = 1;
      end
      if (count > OCTAVES) begin
         count = OCTAVES;
      end
      for (int i = 0; i < count; i++) begin
         acc += 64'(octave_value(sx <<< i, sy <<< i, sz <<< i)) << (OCTAVES - 1 - i);
         total += 64'd1 << (OCTAVES - 1 - i);
      end
      res = normalize_mode ? acc / total : acc >> (OCTAVES - 1);
      if (res > 64'd65535) begin
         res = 64'd65535;
      end
      return res[15:0];
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   // Track register writes, predict accepted points, compare result words.
   always @(posedge clock) begin
      if (reset) begin
         octave_count = OCTAVE_COUNT_RST;
         normalize_mode = NORMALIZE_RST;
         expected_noise.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_OCTAVE_COUNT) begin
               octave_count = pwdata[COUNT_W-1:0];
            end else begin
               normalize_mode = pwdata[0];
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_noise.size() == 0) begin
               report_mismatch($sformatf("unexpected noise word %0d", rsp_noise_value));
            end else if (rsp_noise_value !== expected_noise[0]) begin
               report_mismatch($sformatf("noise word %0d, predicted %0d",
                                         rsp_noise_value, expected_noise[0]));
               void'(expected_noise.pop_front());
            end else begin
               void'(expected_noise.pop_front());
            end
         end
         if (req_valid && !req_stall) begin
            expected_noise.push_back(predict_noise(req_coord_x, req_coord_y, req_coord_z));
         end
      end
      pending = expected_noise.size();
   end

endmodule

@@ verif/tb.sv @@
// Testbench top for fractal_value_noise_3d: drives points and register writes
// under several idling patterns and gives the verdict. Depends on fvn_pkg, noise_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fvn_pkg::*;

   localparam int DRAIN_CYCLES = MAX_OCTAVES_DEF + 20;
   localparam logic [CSR_ADDR_W-1:0] ADDR_OCTAVES   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_NORMALIZE = 3'd4;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [COORD_W-1:0] req_coord_x = '0;
   logic signed [COORD_W-1:0] req_coord_y = '0;
   logic signed [COORD_W-1:0] req_coord_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [VALUE_W-1:0] rsp_noise_value;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;
   int fail_count;
   int pending;

   // Idling percentages and the long receiver hold-off request.
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   logic hold_req = 1'b0;
   int hold_cnt = 0;

   fractal_value_noise_3d DUT (.*);

   noise_checker checker_i (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Receiver: one long hold-off once requested, else random stalls.
   always @(negedge clock) begin
      if (hold_req && hold_cnt < 120) begin
         rsp_stall <= 1'b1;
         hold_cnt <= hold_cnt + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   // Offer one point word and hold it until it is taken; returns at a falling edge.
   task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic [COORD_W-1:0] z);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
   endtask

   // Let every predicted word arrive, then give the pipeline time to empty.
   task automatic drain;
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Random coordinate: mostly full range, sometimes a few cells around zero.
   function automatic logic [COORD_W-1:0] rand_coord;
      if ($urandom_range(3) == 0) begin
         return COORD_W'($signed($urandom_range(1 << 20)) - (1 << 19));
      end
      return COORD_W'($urandom);
   endfunction

   // Register settings and idling of each random phase.
   int phase_octaves [7] = '{8, 1, 0, 15, 8, 2, 5};
   int phase_norm [7] = '{1, 0, 1, 0, 0, 1, 1};
   idle_mode_type phase_idle [7] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                                     IDLE_NONE, IDLE_RECEIVER, IDLE_SENDER};

   initial begin
      logic [COORD_W-1:0] cmax, cmin;
      cmax = {1'b0, {(COORD_W-1){1'b1}}};
      cmin = {1'b1, {(COORD_W-1){1'b0}}};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed points at the reset settings: extremes, cell edges, mixed signs.
      send_point('0, '0, '0);
      send_point(cmax, cmax, cmax);
      send_point(cmin, cmin, cmin);
      send_point('1, '1, '1);
      send_point(cmax, cmin, '0);
      send_point(28'h000FFFF, 28'h0008000, 28'h0010000);
      send_point(28'hFFF0000, 28'hFFFFFFF, 28'h000FFFF);
      send_point(28'h7FF0000, 28'h800FFFF, 28'h0000001);
      send_point(28'h5555555, 28'hAAAAAAA, 28'h3C3C3C3);
      send_point(28'hAAAAAAA, 28'h5555555, 28'hC3C3C3C);
      drain();

      for (int p = 0; p < 7; p++) begin
         write_reg(ADDR_OCTAVES, phase_octaves[p]);
         write_reg(ADDR_NORMALIZE, phase_norm[p]);
         tx_idle_pct = 0;
         rx_idle_pct = 0;
         case (phase_idle[p])
            IDLE_SENDER: begin
               tx_idle_pct = 85;
            end
            IDLE_RECEIVER: begin
               rx_idle_pct = 85;
            end
            IDLE_BOTH: begin
               tx_idle_pct = 19;
               rx_idle_pct = 19;
            end
            default: begin
            end
         endcase
         // A full-range point at each setting, then random ones.
         send_point(cmax, cmin, cmax);
         if (p == 0) begin
            hold_req = 1'b1;
         end
         for (int n = 0; n < 76; n++) begin
            send_point(rand_coord(), rand_coord(), rand_coord());
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("status: fail");
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/fvn_pkg.sv
hw/rtl/fvn_cell.sv
hw/rtl/fvn_norm.sv
hw/rtl/fractal_value_noise_3d.sv
verif/noise_checker.sv
verif/tb.sv
